// File: rtl/uhcdp_pkg.sv
// ----------------------------------------------------------------------------
// uhcdp_pkg: shared types and constants for the HID configuration parser
// Descriptor codes, slot limit, result word layout and result queue sizing.
// ----------------------------------------------------------------------------
package uhcdp_pkg;

	// Number of interrupt IN endpoint slots (1 to 8)
	localparam int unsigned SLOTS = 8;
	localparam logic [3:0] SLOT_LIMIT = 4'(SLOTS);

	// Result queue
	localparam int unsigned RES_DEPTH = 4;
	localparam int unsigned RES_PTR_W = $clog2(RES_DEPTH);
	localparam int unsigned RES_CNT_W = RES_PTR_W + 1;

	// Descriptor type codes
	localparam logic [7:0] DT_INTERFACE = 8'h04;
	localparam logic [7:0] DT_ENDPOINT  = 8'h05;
	localparam logic [7:0] DT_HID       = 8'h21;
	localparam logic [7:0] DT_REPORT    = 8'h22;

	localparam logic [7:0] HID_CLASS     = 8'h03;
	localparam logic [7:0] SUBCLASS_BOOT = 8'h01;
	localparam logic [7:0] PROTO_KBD     = 8'h01;
	localparam logic [7:0] PROTO_MOUSE   = 8'h02;
	localparam logic [1:0] EP_XFER_INT   = 2'b11;

	// Minimum legal bLength
	localparam logic [7:0] MIN_LENGTH = 8'd2;

	// Result kind codes
	localparam logic RK_SLOT = 1'b0;
	localparam logic RK_END  = 1'b1;

	// End status codes
	localparam logic ES_OK  = 1'b0;
	localparam logic ES_BAD = 1'b1;

	typedef enum logic [1:0] {
		KIND_UNKNOWN  = 2'd0,
		KIND_KEYBOARD = 2'd1,
		KIND_MOUSE    = 2'd2
	} device_kind_t;

	typedef struct packed {
		device_kind_t kind;
		logic         boot;
		logic [7:0]   number;
	} iface_info_t;

	typedef struct packed {
		logic         result_kind;
		logic         end_status;
		logic [2:0]   slot_index;
		logic [7:0]   interface_number;
		logic         boot_capable;
		device_kind_t device_kind;
		logic [3:0]   endpoint_number;
		logic [7:0]   max_packet;
		logic [7:0]   poll_interval;
		logic [15:0]  report_length;
		logic         last_result;
	} result_t;

endpackage

// File: rtl/usb_hid_config_descriptor_parser.sv
// ----------------------------------------------------------------------------
// usb_hid_config_descriptor_parser: HID slot extractor for configuration blobs
// Splits a configuration descriptor set into descriptors and reports HID
// interrupt IN endpoints and an end-of-blob status.
// ----------------------------------------------------------------------------
// Takes one descriptor byte per cycle while in_stall is low and parses it in
// the same cycle it is accepted. Each byte yields zero, one or two result
// words (a slot record when it completes a qualifying endpoint descriptor,
// an end status on the last byte of a blob). Words wait in a four-entry
// queue that hands out one word per cycle while out_stall is low; the input
// stalls while fewer than two entries are free, so a steady stream runs at
// one byte per cycle as long as the output keeps up.
module usb_hid_config_descriptor_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  desc_byte,
	input  logic        first_of_device,
	input  logic        first_of_blob,
	input  logic        last_of_blob,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        result_kind,
	output logic        end_status,
	output logic [2:0]  slot_index,
	output logic [7:0]  interface_number,
	output logic        boot_capable,
	output logic [1:0]  device_kind,
	output logic [3:0]  endpoint_number,
	output logic [7:0]  max_packet,
	output logic [7:0]  poll_interval,
	output logic [15:0] report_length,
	output logic        last_result
);

	logic               take;
	logic               full;
	logic [1:0]         res_count;
	uhcdp_pkg::result_t res0, res1, head;

	assign in_stall = full;
	assign take     = in_valid && !full;

	uhcdp_parser u_parser (
		.clk             (clk),
		.arst_n          (arst_n),
		.take            (take),
		.desc_byte       (desc_byte),
		.first_of_device (first_of_device),
		.first_of_blob   (first_of_blob),
		.last_of_blob    (last_of_blob),
		.res0            (res0),
		.res1            (res1),
		.res_count       (res_count)
	);

	uhcdp_res_fifo u_res_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_count (res_count),
		.wr0        (res0),
		.wr1        (res1),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.head       (head),
		.full       (full)
	);

	assign result_kind      = head.result_kind;
	assign end_status       = head.end_status;
	assign slot_index       = head.slot_index;
	assign interface_number = head.interface_number;
	assign boot_capable     = head.boot_capable;
	assign device_kind      = head.device_kind;
	assign endpoint_number  = head.endpoint_number;
	assign max_packet       = head.max_packet;
	assign poll_interval    = head.poll_interval;
	assign report_length    = head.report_length;
	assign last_result      = head.last_result;

endmodule

// File: rtl/uhcdp_parser.sv
// ----------------------------------------------------------------------------
// uhcdp_parser: byte-serial descriptor splitter and HID slot extractor
// Tracks the offset within the current descriptor, latches interface and
// HID fields, and forms up to two result words for each accepted byte.
// ----------------------------------------------------------------------------
module uhcdp_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  logic [7:0]          desc_byte,
	input  logic                first_of_device,
	input  logic                first_of_blob,
	input  logic                last_of_blob,
	output uhcdp_pkg::result_t  res0,
	output uhcdp_pkg::result_t  res1,
	output logic [1:0]          res_count
);

	logic [7:0]             byte_position_q, byte_position_d;
	logic [7:0]             current_length_q, current_length_d;
	logic [7:0]             current_type_q, current_type_d;
	logic [7:0]             field_q [6];
	logic [7:0]             field_d [6];
	logic                   good_interface_q, good_interface_d;
	uhcdp_pkg::iface_info_t iface_info_q, iface_info_d;
	logic [15:0]            report_len_q, report_len_d;
	logic [3:0]             slot_count_q, slot_count_d;
	logic                   error_seen_q, error_seen_d;

	logic [7:0]             pos;
	logic                   rec_hit;
	uhcdp_pkg::result_t     rec;
	uhcdp_pkg::result_t     end_res;

	always_comb begin
		slot_count_d     = first_of_device ? 4'd0 : slot_count_q;
		byte_position_d  = byte_position_q;
		current_length_d = current_length_q;
		current_type_d   = current_type_q;
		field_d          = field_q;
		good_interface_d = good_interface_q;
		iface_info_d     = iface_info_q;
		report_len_d     = report_len_q;
		error_seen_d     = error_seen_q;
		rec_hit          = 1'b0;
		rec              = '0;
		end_res          = '0;

		if (first_of_blob) begin
			byte_position_d  = '0;
			current_length_d = '0;
			current_type_d   = '0;
			field_d          = '{default: '0};
			good_interface_d = 1'b0;
			iface_info_d     = '0;
			report_len_d     = '0;
			error_seen_d     = 1'b0;
		end
		pos = byte_position_d;

		if (!error_seen_d) begin
			if (pos == 8'd0) begin
				field_d          = '{default: '0};
				current_length_d = desc_byte;
				current_type_d   = '0;
				if (desc_byte < uhcdp_pkg::MIN_LENGTH) begin
					error_seen_d = 1'b1;
				end
			end else if (pos == 8'd1) begin
				current_type_d = desc_byte;
			end else if (pos <= 8'd7) begin
				field_d[pos[2:0] - 3'd2] = desc_byte;
			end

			if (!error_seen_d) begin
				if (pos == 8'd8 && current_type_d == uhcdp_pkg::DT_HID && good_interface_d &&
						field_d[4] == uhcdp_pkg::DT_REPORT) begin
					report_len_d = {desc_byte, field_d[5]};
				end
				if ({1'b0, pos} + 9'd1 >= {1'b0, current_length_d}) begin
					byte_position_d = '0;
					if (current_type_d == uhcdp_pkg::DT_INTERFACE) begin
						good_interface_d = 1'b0;
						if (field_d[3] == uhcdp_pkg::HID_CLASS &&
								slot_count_d < uhcdp_pkg::SLOT_LIMIT) begin
							good_interface_d    = 1'b1;
							iface_info_d.number = field_d[0];
							iface_info_d.boot   = (field_d[4] == uhcdp_pkg::SUBCLASS_BOOT);
							if (field_d[5] == uhcdp_pkg::PROTO_KBD) begin
								iface_info_d.kind = uhcdp_pkg::KIND_KEYBOARD;
							end else if (field_d[5] == uhcdp_pkg::PROTO_MOUSE) begin
								iface_info_d.kind = uhcdp_pkg::KIND_MOUSE;
							end else begin
								iface_info_d.kind = uhcdp_pkg::KIND_UNKNOWN;
							end
							report_len_d = '0;
						end
					end else if (current_type_d == uhcdp_pkg::DT_ENDPOINT) begin
						// interrupt IN endpoint under an accepted interface takes a slot
						if (good_interface_d && field_d[1][1:0] == uhcdp_pkg::EP_XFER_INT &&
								field_d[0][7] && slot_count_d < uhcdp_pkg::SLOT_LIMIT) begin
							rec_hit              = 1'b1;
							rec.result_kind      = uhcdp_pkg::RK_SLOT;
							rec.end_status       = uhcdp_pkg::ES_OK;
							rec.slot_index       = slot_count_d[2:0];
							rec.interface_number = iface_info_d.number;
							rec.boot_capable     = iface_info_d.boot;
							rec.device_kind      = iface_info_d.kind;
							rec.endpoint_number  = field_d[0][3:0];
							rec.max_packet       = field_d[2];
							rec.poll_interval    = field_d[4];
							rec.report_length    = report_len_d;
							rec.last_result      = 1'b1;
							slot_count_d         = slot_count_d + 4'd1;
						end
					end
				end else begin
					byte_position_d = pos + 8'd1;
				end
			end
		end

		if (last_of_blob) begin
			// the end status word becomes the final word of this byte
			rec.last_result    = 1'b0;
			end_res.result_kind = uhcdp_pkg::RK_END;
			end_res.end_status  = (error_seen_d || byte_position_d != 8'd0) ?
					uhcdp_pkg::ES_BAD : uhcdp_pkg::ES_OK;
			end_res.last_result = 1'b1;
			byte_position_d  = '0;
			current_length_d = '0;
			current_type_d   = '0;
			field_d          = '{default: '0};
			good_interface_d = 1'b0;
			iface_info_d     = '0;
			report_len_d     = '0;
			error_seen_d     = 1'b0;
		end

		res0      = rec_hit ? rec : end_res;
		res1      = end_res;
		res_count = take ? ({1'b0, rec_hit} + {1'b0, last_of_blob}) : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_position_q  <= '0;
			current_length_q <= '0;
			current_type_q   <= '0;
			field_q          <= '{default: '0};
			good_interface_q <= 1'b0;
			iface_info_q     <= '0;
			report_len_q     <= '0;
			slot_count_q     <= '0;
			error_seen_q     <= 1'b0;
		end else if (take) begin
			byte_position_q  <= byte_position_d;
			current_length_q <= current_length_d;
			current_type_q   <= current_type_d;
			field_q          <= field_d;
			good_interface_q <= good_interface_d;
			iface_info_q     <= iface_info_d;
			report_len_q     <= report_len_d;
			slot_count_q     <= slot_count_d;
			error_seen_q     <= error_seen_d;
		end
	end

	a_slot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		slot_count_q <= uhcdp_pkg::SLOT_LIMIT)
		else $error("slot count beyond slot limit");

	a_error_parks: assert property (@(posedge clk) disable iff (!arst_n)
		error_seen_q |-> byte_position_q == 8'd0)
		else $error("parser advanced after a malformed length");

	a_blob_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		take && last_of_blob |=> !error_seen_q && byte_position_q == 8'd0 && !good_interface_q)
		else $error("parser not restarted after the last byte");

endmodule

// File: rtl/uhcdp_res_fifo.sv
// ----------------------------------------------------------------------------
// uhcdp_res_fifo: small result word queue
// Takes up to two words a cycle, hands out one word a cycle while out_stall
// is low, and flags full while fewer than two places are free.
// ----------------------------------------------------------------------------
module uhcdp_res_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [1:0]          push_count,
	input  uhcdp_pkg::result_t  wr0,
	input  uhcdp_pkg::result_t  wr1,
	input  logic                out_stall,
	output logic                out_valid,
	output uhcdp_pkg::result_t  head,
	output logic                full
);

	uhcdp_pkg::result_t                    entry_q [uhcdp_pkg::RES_DEPTH];
	logic [uhcdp_pkg::RES_PTR_W-1:0]       wr_ptr_q, rd_ptr_q;
	logic [uhcdp_pkg::RES_PTR_W-1:0]       wr_ptr_next;
	logic [uhcdp_pkg::RES_CNT_W-1:0]       count_q;
	logic                                  pop;

	assign out_valid   = (count_q != '0);
	assign head        = entry_q[rd_ptr_q];
	assign pop         = out_valid && !out_stall;
	assign full        = (count_q > uhcdp_pkg::RES_CNT_W'(uhcdp_pkg::RES_DEPTH - 2));
	assign wr_ptr_next = wr_ptr_q + uhcdp_pkg::RES_PTR_W'(1);

	always_ff @(posedge clk) begin
		if (push_count != 2'd0) begin
			entry_q[wr_ptr_q] <= wr0;
		end
		if (push_count == 2'd2) begin
			entry_q[wr_ptr_next] <= wr1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + uhcdp_pkg::RES_PTR_W'(push_count);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + uhcdp_pkg::RES_PTR_W'(1);
			end
			count_q <= count_q + uhcdp_pkg::RES_CNT_W'(push_count)
					- uhcdp_pkg::RES_CNT_W'(pop);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= uhcdp_pkg::RES_CNT_W'(uhcdp_pkg::RES_DEPTH))
		else $error("result queue overfilled");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push_count != 2'd0 |-> !full)
		else $error("word pushed while queue full");

endmodule
